// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the thermal collision block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// condition must never be seen at a rising edge outside reset
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`endif

// ===== sv/tlbm_pkg.sv =====
// ----------------------------------------------------------------------------
// tlbm_pkg
// types and constants of the thermal lattice boltzmann collision block
// ----------------------------------------------------------------------------
package tlbm_pkg;

   localparam int MAX_DIRS   = 7;
   localparam int FIELD_W    = 24;
   localparam int CSR_DATA_W = 64;
   localparam int PIPE_DEPTH = 6;

   // omega divider: 2^40 + den/2 divided by a 26-bit denominator
   localparam int DEN_W     = 26;
   localparam int NUM_W     = 41;
   localparam int DIV_STEPS = NUM_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
   localparam int OMEGA_W   = 24;

   localparam logic [OMEGA_W-1:0] OMEGA_RESET = 24'd1310718;
   localparam logic [OMEGA_W-1:0] OMEGA_MAX   = 24'd2097152;

   typedef enum logic [1:0] {
      CSR_DIFFUSIVITY  = 2'd0,
      CSR_VELOCITY_SET = 2'd1,
      CSR_WEIGHTS_LOW  = 2'd2,
      CSR_WEIGHTS_HIGH = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] temperature;
      logic signed [FIELD_W-1:0] vel_x;
      logic signed [FIELD_W-1:0] vel_y;
      logic signed [FIELD_W-1:0] vel_z;
      logic signed [FIELD_W-1:0] pop_0;
      logic signed [FIELD_W-1:0] pop_1;
      logic signed [FIELD_W-1:0] pop_2;
      logic signed [FIELD_W-1:0] pop_3;
      logic signed [FIELD_W-1:0] pop_4;
      logic signed [FIELD_W-1:0] pop_5;
      logic signed [FIELD_W-1:0] pop_6;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] out_0;
      logic signed [FIELD_W-1:0] out_1;
      logic signed [FIELD_W-1:0] out_2;
      logic signed [FIELD_W-1:0] out_3;
      logic signed [FIELD_W-1:0] out_4;
      logic signed [FIELD_W-1:0] out_5;
      logic signed [FIELD_W-1:0] out_6;
   } rsp_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [OMEGA_W-1:0] quotient;
   } div_status_type;

endpackage

// ===== sv/tlbm_omega_div.sv =====
// ----------------------------------------------------------------------------
// tlbm_omega_div
// restoring divider, one quotient bit per cycle: omega = round(2^40 / den)
// ----------------------------------------------------------------------------
module tlbm_omega_div
   import tlbm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [FIELD_W-1:0]   diffusivity,
   output div_status_type       status
);

   logic [DIV_CNT_W-1:0] cnt_ff,  cnt_in;
   logic                 done_ff, done_in;
   logic [DEN_W-1:0]     den_ff,  den_in;
   logic [DEN_W-1:0]     rem_ff,  rem_in;
   logic [NUM_W-1:0]     quo_ff,  quo_in;

   logic [DEN_W-1:0]     den_new;
   logic [DEN_W:0]       trial;
   logic                 ge;

   // den = 3*alpha + 0.5 in q20
   assign den_new = ({2'b00, diffusivity} << 1) + {2'b00, diffusivity} + 26'd524288;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         cnt_in = DIV_CNT_W'(DIV_STEPS);
         den_in = den_new;
         rem_in = '0;
         // numerator carries the rounding half of the denominator
         quo_in = {1'b1, 40'd0} + NUM_W'(den_new >> 1);
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == DIV_CNT_W'(1));
         rem_in  = ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         quo_in  = {quo_ff[NUM_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign status.busy     = (cnt_ff != '0) || done_ff;
   assign status.done     = done_ff;
   assign status.quotient = quo_ff[OMEGA_W-1:0];

endmodule

// ===== sv/tlbm_lane.sv =====
// ----------------------------------------------------------------------------
// tlbm_lane
// six-stage collision pipeline for one lattice direction
// ----------------------------------------------------------------------------
module tlbm_lane
   import tlbm_pkg::*;
(
   input  logic                      clock,
   input  logic signed [FIELD_W-1:0] theta,
   input  logic signed [FIELD_W-1:0] vel_x,
   input  logic signed [FIELD_W-1:0] vel_y,
   input  logic signed [FIELD_W-1:0] vel_z,
   input  logic signed [FIELD_W-1:0] pop,
   input  logic [5:0]                dir_vec,
   input  logic [15:0]               weight,
   input  logic [21:0]               omega,
   input  logic signed [22:0]        keep,
   output logic signed [FIELD_W-1:0] result
);

   // stage 1: projection and weight product
   logic signed [25:0] px, py, pz;
   logic signed [26:0] cu;
   logic signed [28:0] term_in,  term1_ff, term2_ff;
   logic signed [40:0] wprod_in, wprod_ff;
   logic signed [FIELD_W-1:0] n1_ff;

   // stage 2: rounded weight times theta, keep times population
   logic signed [40:0] wrnd;
   logic signed [24:0] wt_in, wt_ff;
   logic signed [46:0] keepn_in, keepn2_ff, keepn3_ff, keepn4_ff, keepn5_ff;

   // stage 3 to 5: equilibrium and its relaxed share
   logic signed [53:0] prod_in, prod_ff;
   logic signed [53:0] prnd;
   logic signed [31:0] neq_in, neq_ff;
   logic signed [54:0] oneq_in, oneq_ff;

   // stage 6: sum, round, saturate
   logic signed [54:0] acc;
   logic signed [54:0] arnd;
   logic signed [34:0] res_wide;
   logic signed [FIELD_W-1:0] result_in, result_ff;

   assign px = $signed(dir_vec[1:0]) * vel_x;
   assign py = $signed(dir_vec[3:2]) * vel_y;
   assign pz = $signed(dir_vec[5:4]) * vel_z;
   assign cu = 27'(px) + 27'(py) + 27'(pz);

   assign term_in  = 29'(cu) + 29'(cu) + 29'(cu) + 29'sd1048576;
   assign wprod_in = $signed({1'b0, weight}) * theta;

   assign wrnd     = wprod_ff + 41'sd32768;
   assign wt_in    = wrnd[40:16];
   assign keepn_in = keep * n1_ff;

   assign prod_in = wt_ff * term2_ff;

   assign prnd   = prod_ff + 54'sd524288;
   assign neq_in = prnd[51:20];

   assign oneq_in = $signed({1'b0, omega}) * neq_ff;

   assign acc      = oneq_ff + 55'(keepn5_ff);
   assign arnd     = acc + 55'sd524288;
   assign res_wide = arnd[54:20];

   always_comb begin
      if (res_wide > 35'sd8388607) begin
         result_in = 24'sh7fffff;
      end else if (res_wide < -35'sd8388608) begin
         result_in = 24'sh800000;
      end else begin
         result_in = res_wide[FIELD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      term1_ff  <= term_in;
      wprod_ff  <= wprod_in;
      n1_ff     <= pop;
      term2_ff  <= term1_ff;
      wt_ff     <= wt_in;
      keepn2_ff <= keepn_in;
      prod_ff   <= prod_in;
      keepn3_ff <= keepn2_ff;
      neq_ff    <= neq_in;
      keepn4_ff <= keepn3_ff;
      oneq_ff   <= oneq_in;
      keepn5_ff <= keepn4_ff;
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

// ===== sv/thermal_lbm_collision.sv =====
// ----------------------------------------------------------------------------
// thermal_lbm_collision
// bgk collision of one thermal lattice node, one direction lane per population
// ----------------------------------------------------------------------------
// rsp_valid comes from a valid shift register that runs alongside the lane pipeline
// throughput: one node per cycle while busy is low, through the six-stage lane pipeline
// a diffusivity write holds busy high while the serial divider runs
// synchronous reset clears the pipeline valids, velocity set and weights and loads the default omega
// results cannot be stalled; rsp_valid is a one-cycle strobe
`include "assert_macros.svh"

module thermal_lbm_collision
   import tlbm_pkg::*;
#(
   parameter int NUM_DIRS = 7
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  csr_index_type         csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [41:0]           velocity_set_ff, velocity_set_in;
   logic [63:0]           weights_low_ff,  weights_low_in;
   logic [47:0]           weights_high_ff, weights_high_in;
   logic [OMEGA_W-1:0]    omega_ff,        omega_in;
   logic [PIPE_DEPTH-1:0] vld_ff,          vld_in;

   logic                  csr_wr;
   logic                  div_start;
   div_status_type        div_st;
   logic                  accept;
   logic signed [22:0]    keep;

   logic signed [FIELD_W-1:0] pop_arr  [MAX_DIRS];
   logic signed [FIELD_W-1:0] lane_out [MAX_DIRS];
   logic [15:0]               lane_w   [MAX_DIRS];

   assign csr_ready = !div_st.busy;
   assign csr_wr    = csr_valid && csr_ready;
   assign busy      = div_st.busy;
   assign accept    = start && !busy;

   always_comb begin
      velocity_set_in = velocity_set_ff;
      weights_low_in  = weights_low_ff;
      weights_high_in = weights_high_ff;
      div_start       = 1'b0;
      if (csr_wr) begin
         unique case (csr_addr)
            CSR_DIFFUSIVITY:  div_start       = 1'b1;
            CSR_VELOCITY_SET: velocity_set_in = csr_data[41:0];
            CSR_WEIGHTS_LOW:  weights_low_in  = csr_data;
            CSR_WEIGHTS_HIGH: weights_high_in = csr_data[47:0];
            default: ;
         endcase
      end
   end

   assign omega_in = div_st.done ? div_st.quotient : omega_ff;
   assign vld_in   = {vld_ff[PIPE_DEPTH-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         velocity_set_ff <= '0;
         weights_low_ff  <= '0;
         weights_high_ff <= '0;
         omega_ff        <= OMEGA_RESET;
         vld_ff          <= '0;
      end else begin
         velocity_set_ff <= velocity_set_in;
         weights_low_ff  <= weights_low_in;
         weights_high_ff <= weights_high_in;
         omega_ff        <= omega_in;
         vld_ff          <= vld_in;
      end
   end

   tlbm_omega_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .diffusivity (csr_data[FIELD_W-1:0]),
      .status      (div_st)
   );

   // 1 - omega in q20, omega never exceeds 2^21
   assign keep = 23'sd1048576 - $signed({1'b0, omega_ff[21:0]});

   assign pop_arr[0] = req_data.pop_0;
   assign pop_arr[1] = req_data.pop_1;
   assign pop_arr[2] = req_data.pop_2;
   assign pop_arr[3] = req_data.pop_3;
   assign pop_arr[4] = req_data.pop_4;
   assign pop_arr[5] = req_data.pop_5;
   assign pop_arr[6] = req_data.pop_6;

   for (genvar k = 0; k < MAX_DIRS; k++) begin : g_dir
      if (k < 4) begin : g_wlo
         assign lane_w[k] = weights_low_ff[16*k +: 16];
      end else begin : g_whi
         assign lane_w[k] = weights_high_ff[16*(k-4) +: 16];
      end

      if (k < NUM_DIRS) begin : g_lane
         tlbm_lane u_lane (
            .clock   (clock),
            .theta   (req_data.temperature),
            .vel_x   (req_data.vel_x),
            .vel_y   (req_data.vel_y),
            .vel_z   (req_data.vel_z),
            .pop     (pop_arr[k]),
            .dir_vec (velocity_set_ff[6*k +: 6]),
            .weight  (lane_w[k]),
            .omega   (omega_ff[21:0]),
            .keep    (keep),
            .result  (lane_out[k])
         );
      end else begin : g_unused
         assign lane_out[k] = '0;
      end
   end

   assign rsp_valid      = vld_ff[PIPE_DEPTH-1];
   assign rsp_data.out_0 = lane_out[0];
   assign rsp_data.out_1 = lane_out[1];
   assign rsp_data.out_2 = lane_out[2];
   assign rsp_data.out_3 = lane_out[3];
   assign rsp_data.out_4 = lane_out[4];
   assign rsp_data.out_5 = lane_out[5];
   assign rsp_data.out_6 = lane_out[6];

   // every accepted transaction comes out on rsp_valid, and every rsp_valid traces back to one
   `ASSERT_CLK(a_latency, clock, reset, accept |-> ##PIPE_DEPTH rsp_valid)
   `ASSERT_CLK(a_rsp_origin, clock, reset, rsp_valid |-> $past(accept, PIPE_DEPTH))
   `ASSERT_CLK(a_div_start, clock, reset, (csr_wr && csr_addr == CSR_DIFFUSIVITY) |=> busy)
   `ASSERT_NEVER(a_omega_range, clock, reset, omega_ff > OMEGA_MAX)

endmodule

// ===== tb/tb_thermal_lbm_collision.sv =====
// ----------------------------------------------------------------------------
// tb_thermal_lbm_collision
// self-checking bench for the thermal lattice boltzmann bgk collision block
// ----------------------------------------------------------------------------
// a queue of nodes feeds a bursty command driver; every accepted node is run
// through a bit-exact fixed-point collision predictor and the post-collision
// populations are queued; the monitor checks each rsp_valid strobe lane by lane
// against the oldest queued entry. csr writes happen only with the block
// drained and sweep diffusivity extremes, velocity sets and weight tables.
module tb_thermal_lbm_collision;
   import tlbm_pkg::*;

   localparam int NUM_DIRS       = 7;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int NODES_PER_SET  = 200;
   localparam int NUM_SETS       = 8;

   // d3q7: rest, +x, -x, +y, -y, +z, -z
   localparam logic [CSR_DATA_W-1:0] D3Q7_DIRS =
      (64'h1 << 6) | (64'h3 << 12) | (64'h1 << 20) | (64'h3 << 26) |
      (64'h1 << 34) | (64'h3 << 40);
   localparam logic [CSR_DATA_W-1:0] D3Q7_W_LOW  = 64'h2000_2000_2000_4000;
   localparam logic [CSR_DATA_W-1:0] D3Q7_W_HIGH = 64'h0000_2000_2000_2000;
   // every component coded as 2'b10
   localparam logic [CSR_DATA_W-1:0] ALL_MINUS_TWO = 64'h0000_02AA_AAAA_AAAA;
   localparam logic [23:0] ALPHA_RESET = 24'd104858;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_index_type csr_addr = CSR_DIFFUSIVITY;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // predictor copy of the register file
   logic [23:0] alpha_q = ALPHA_RESET;
   logic [41:0] dirs_q = '0;
   logic [63:0] wlo_q = '0;
   logic [47:0] whi_q = '0;
   logic [23:0] omega_q;

   req_type node_queue[$];
   rsp_type relaxed_pops[$];
   int failures = 0;
   int quiet_cycles = 0;
   int burst_left = 1;
   int gap_left = 0;

   thermal_lbm_collision #(.NUM_DIRS(NUM_DIRS)) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_addr  (csr_addr),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   function automatic logic [23:0] relaxation_for(logic [23:0] alpha);
      longint unsigned den;
      den = 3 * longint'(alpha) + (64'd1 << 19);
      return 24'(((64'd1 << 40) + den / 2) / den);
   endfunction

   function automatic rsp_type collide(req_type n);
      rsp_type r;
      longint th, ux, uy, uz, cx, cy, cz, cu, term, w, wt, neq, acc, pop, om, keep;
      r = '0;
      th = n.temperature;
      ux = n.vel_x;
      uy = n.vel_y;
      uz = n.vel_z;
      om = longint'(omega_q);
      keep = (longint'(1) <<< 20) - om;
      for (int k = 0; k < NUM_DIRS; k++) begin
         cx = $signed(dirs_q[6*k +: 2]);
         cy = $signed(dirs_q[6*k+2 +: 2]);
         cz = $signed(dirs_q[6*k+4 +: 2]);
         cu = cx * ux + cy * uy + cz * uz;
         term = (longint'(1) <<< 20) + 3 * cu;
         w = (k < 4) ? longint'(wlo_q[16*k +: 16]) : longint'(whi_q[16*(k-4) +: 16]);
         wt = (w * th + 32768) >>> 16;
         neq = (wt * term + (longint'(1) <<< 19)) >>> 20;
         // pop_k and out_k sit at the same lane offset in the packed structs
         pop = $signed(n[24*(6-k) +: 24]);
         acc = (keep * pop + om * neq + (longint'(1) <<< 19)) >>> 20;
         if (acc > 8388607) acc = 8388607;
         if (acc < -8388608) acc = -8388608;
         r[24*(6-k) +: 24] = acc[23:0];
      end
      return r;
   endfunction

   function automatic logic [23:0] near_zero(int bits);
      int lim;
      lim = 1 << bits;
      return 24'(int'($urandom_range(0, 2 * lim)) - lim);
   endfunction

   function automatic logic [23:0] corner();
      case ($urandom_range(0, 4))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'h000000;
         3: return 24'hFFFFFF;
         default: return 24'h000001;
      endcase
   endfunction

   function automatic req_type random_node();
      req_type n;
      int unsigned mode;
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 11; i++) begin
         n[24*i +: 24] = 24'($urandom);
         // slices 7..9 are the velocity components, 10 the temperature
         if (mode < 6) begin
            n[24*i +: 24] = near_zero((i >= 7 && i <= 9) ? $urandom_range(10, 19) : 21);
         end else if (mode < 8 && $urandom_range(0, 1) == 0) begin
            n[24*i +: 24] = corner();
         end
      end
      return n;
   endfunction

   function automatic req_type flat_node(logic [23:0] t, logic [23:0] u, logic [23:0] p);
      return '{t, u, u, u, p, p, p, p, p, p, p};
   endfunction

   task automatic wait_idle();
      do @(posedge clock);
      while (node_queue.size() != 0 || start || relaxed_pops.size() != 0);
   endtask

   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_addr <= idx;
      csr_data <= value;
      do @(posedge clock);
      while (!csr_ready);
      case (idx)
         CSR_DIFFUSIVITY: begin
            alpha_q = value[23:0];
            omega_q = relaxation_for(alpha_q);
         end
         CSR_VELOCITY_SET: dirs_q = value[41:0];
         CSR_WEIGHTS_LOW: wlo_q = value;
         CSR_WEIGHTS_HIGH: whi_q = value[47:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   // command driver: bursts of nodes with random gaps, held while busy
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            relaxed_pops.push_back(collide(req_data));
         end
         if (start && busy) begin
            // hold the node until the block takes it
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (node_queue.size() != 0) begin
            start <= 1'b1;
            req_data <= node_queue.pop_front();
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (relaxed_pops.size() == 0) begin
            $display("%0t unexpected transaction: expected none, got %h", $time, rsp_data);
            failures++;
         end else begin
            want = relaxed_pops.pop_front();
            for (int k = 0; k < 7; k++) begin
               if (rsp_data[24*(6-k) +: 24] !== want[24*(6-k) +: 24]) begin
                  $display("%0t out_%0d mismatch: expected %0d, got %0d", $time, k,
                           $signed(want[24*(6-k) +: 24]),
                           $signed(rsp_data[24*(6-k) +: 24]));
                  failures++;
               end
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [CSR_DATA_W-1:0] junk;
      logic [23:0] alpha;
      omega_q = relaxation_for(ALPHA_RESET);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset register state: zero weights, omega from default diffusivity
      node_queue.push_back(flat_node(24'h0, 24'h0, 24'h0));
      node_queue.push_back(flat_node(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
      node_queue.push_back(flat_node(24'h800000, 24'h800000, 24'h800000));
      node_queue.push_back(flat_node(24'h100000, 24'h0, 24'h800000));

      // standard d3q7 lattice, garbage above each register's width
      junk = {$urandom, $urandom};
      csr_write(CSR_DIFFUSIVITY, {junk[63:24], ALPHA_RESET});
      csr_write(CSR_VELOCITY_SET, {junk[63:42], D3Q7_DIRS[41:0]});
      csr_write(CSR_WEIGHTS_LOW, D3Q7_W_LOW);
      csr_write(CSR_WEIGHTS_HIGH, {junk[63:48], D3Q7_W_HIGH[47:0]});
      node_queue.push_back(flat_node(24'h0, 24'h0, 24'h0));
      node_queue.push_back(flat_node(24'h7FFFFF, 24'h0, 24'h0));
      node_queue.push_back(flat_node(24'h800000, 24'h0, 24'h0));
      node_queue.push_back(flat_node(24'h100000, 24'd104858, 24'd149797));
      node_queue.push_back(flat_node(24'h7FFFFF, 24'h7FFFFF, 24'h0));
      node_queue.push_back(flat_node(24'h7FFFFF, 24'h800000, 24'h0));
      node_queue.push_back(flat_node(24'h0, 24'h0, 24'h7FFFFF));
      node_queue.push_back(flat_node(24'h0, 24'h0, 24'h800000));
      node_queue.push_back(flat_node(24'hFFFFFF, 24'hFFFFFF, 24'h000001));
      node_queue.push_back(req_type'{24'h100000, 24'h7FFFFF, 24'h800000, 24'h0,
                                     24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000,
                                     24'h0, 24'hFFFFFF, 24'h000001});

      // component code 10 everywhere, full weights, smallest diffusivity
      csr_write(CSR_DIFFUSIVITY, 64'h0);
      csr_write(CSR_VELOCITY_SET, ALL_MINUS_TWO);
      csr_write(CSR_WEIGHTS_LOW, {64{1'b1}});
      csr_write(CSR_WEIGHTS_HIGH, {64{1'b1}});
      node_queue.push_back(flat_node(24'h7FFFFF, 24'h800000, 24'h0));
      node_queue.push_back(flat_node(24'h800000, 24'h7FFFFF, 24'h0));
      node_queue.push_back(flat_node(24'h100000, 24'h040000, 24'h0));
      node_queue.push_back(flat_node(24'h000001, 24'hFFFFFF, 24'h800000));

      for (int s = 0; s < NUM_SETS; s++) begin
         case (s % 4)
            0: alpha = 24'h0;
            1: alpha = 24'hFFFFFF;
            2: alpha = ALPHA_RESET;
            default: alpha = 24'($urandom_range(0, 24'h3FFFFF));
         endcase
         junk = {$urandom, $urandom};
         csr_write(CSR_DIFFUSIVITY, {junk[63:24], alpha});
         case ($urandom_range(0, 3))
            0: csr_write(CSR_VELOCITY_SET, ALL_MINUS_TWO);
            1: csr_write(CSR_VELOCITY_SET, {$urandom, $urandom});
            default: csr_write(CSR_VELOCITY_SET, D3Q7_DIRS);
         endcase
         case ($urandom_range(0, 3))
            0: begin
               csr_write(CSR_WEIGHTS_LOW, {$urandom, $urandom});
               csr_write(CSR_WEIGHTS_HIGH, {$urandom, $urandom});
            end
            1: begin
               csr_write(CSR_WEIGHTS_LOW, (s == 7) ? 64'h0 : {64{1'b1}});
               csr_write(CSR_WEIGHTS_HIGH, (s == 7) ? 64'h0 : {64{1'b1}});
            end
            default: begin
               csr_write(CSR_WEIGHTS_LOW, D3Q7_W_LOW);
               csr_write(CSR_WEIGHTS_HIGH, D3Q7_W_HIGH);
            end
         endcase
         for (int i = 0; i < NODES_PER_SET; i++) begin
            node_queue.push_back(random_node());
         end
      end

      wait_idle();
      repeat (4 * PIPE_DEPTH) @(posedge clock);
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
